>>> rtl/ilie_pkg.sv
// Shared types and constants for the indexed list insert/erase unit.
// No dependencies; used by the storage cell and the top level.
`default_nettype none

package ilie_pkg;

  // Capacity of the list and width of one stored word.
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 32;

  // Fixed port widths.
  localparam int unsigned POS_BITS  = 5;
  localparam int unsigned DATA_BITS = 32;

  // Width of a count that can hold DEPTH itself, and of an index into the list.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Width used to compare a position against a count without losing bits.
  localparam int unsigned CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_INSERT   = 3'd2,
    OP_ERASE    = 3'd3,
    OP_READ     = 3'd4,
    OP_ROTATE   = 3'd5,
    OP_TRUNCATE = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell of the row does at each clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_ROTATE
  } cell_op_e;

  // Command broadcast to the whole row of cells.
  typedef struct packed {
    cell_op_e           kind;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   cnt;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/indexed_list_insert_erase_unit.sv
// Top level of the indexed list insert/erase unit: a row of ilie_cell storage
// cells, the operation decoder and the result registers. Depends on ilie_pkg.
`default_nettype none

// Channel  | Direction | Handshake                     | Word
// ---------+-----------+-------------------------------+-----------------------------------
// command  | in        | start high while busy is low  | operation_i, position_i, value_i
// result   | out       | done_o high for one cycle     | read_data_o, status_o,
//          |           |                               | element_count_o
//
// Push, pop, insert, erase, read and truncate complete at the accepting edge, where the
// cells that change load from the input word or a neighbor; the result word is strobed
// in the following cycle. A new command may be given in that cycle. Rotating by p
// positions steps the live words one place left per cycle, the first step at the
// accepting edge; busy is high while the remaining steps run, and done_o follows.
// Reset empties the list at once; the stored words themselves are not cleared.
// The receiver cannot stall the result; each result word stands for one cycle only.

module indexed_list_insert_erase_unit
  import ilie_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           operation_i,
  input  wire logic [POS_BITS-1:0]  position_i,
  input  wire logic [DATA_BITS-1:0] value_i,
  output logic                      done_o,
  output logic [DATA_BITS-1:0]      read_data_o,
  output logic [1:0]                status_o,
  output logic [POS_BITS-1:0]       element_count_o
);

  typedef enum logic {
    S_IDLE,
    S_ROTATE
  } state_e;

  state_e                state_q;
  logic                  done_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      count_d;
  logic [CNT_W-1:0]      steps_q;
  logic [DATA_BITS-1:0]  rdata_q;
  logic [DATA_BITS-1:0]  rdata_d;
  status_e               status_q;
  status_e               status_d;
  logic [POS_BITS-1:0]   ecount_q;

  logic                  accept;
  logic                  rot_start;
  op_e                   op;
  cell_cmd_t             cmd;
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      n_c;
  logic [CMP_W-1:0]      depth_c;
  logic [CMP_W-1:0]      cnt_ext;
  logic [63:0]           value_ext;
  logic [63:0]           rd_ext;
  logic [WORD_BITS-1:0]  cell_word [DEPTH];

  assign accept    = start && (state_q == S_IDLE);
  assign op        = op_e'(operation_i);
  assign pos_c     = CMP_W'(position_i);
  assign n_c       = CMP_W'(count_q);
  assign depth_c   = CMP_W'(DEPTH);
  assign cnt_ext   = CMP_W'(count_d);
  assign value_ext = 64'(value_i);
  assign rd_ext    = 64'(cell_word[pos_c[IDX_W-1:0]]);

  // The row of cells. Each cell sees its neighbors below and above and the
  // front word, which closes the ring during a rotation.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] lower_w;
    logic [WORD_BITS-1:0] upper_w;

    if (g == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_inner_lo
      assign lower_w = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_inner_hi
      assign upper_w = cell_word[g+1];
    end

    ilie_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .index_i (CNT_W'(g)),
      .value_i (value_ext[WORD_BITS-1:0]),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .front_i (cell_word[0]),
      .word_o  (cell_word[g])
    );
  end

  // Decode the accepted command into a row command, the new count and the
  // result word. Index checks come before the full check, as insert requires.
  always_comb begin
    cmd       = '{kind: CELL_HOLD, pos: '0, cnt: count_q};
    count_d   = count_q;
    status_d  = ST_OK;
    rdata_d   = '0;
    rot_start = 1'b0;
    if (state_q == S_ROTATE) begin
      cmd.kind = CELL_ROTATE;
    end else if (accept) begin
      unique case (op)
        OP_PUSH: begin
          if (n_c >= depth_c) begin
            status_d = ST_FULL;
          end else begin
            cmd.kind = CELL_INSERT;
            cmd.pos  = count_q;
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (count_q != '0) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (pos_c > n_c) begin
            status_d = ST_RANGE;
          end else if (n_c >= depth_c) begin
            status_d = ST_FULL;
          end else begin
            cmd.kind = CELL_INSERT;
            cmd.pos  = pos_c[CNT_W-1:0];
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_ERASE: begin
          if (pos_c >= n_c) begin
            status_d = ST_RANGE;
          end else begin
            cmd.kind = CELL_ERASE;
            cmd.pos  = pos_c[CNT_W-1:0];
            count_d  = count_q - CNT_W'(1);
          end
        end
        OP_READ: begin
          if (pos_c >= n_c) begin
            status_d = ST_RANGE;
          end else begin
            rdata_d = rd_ext[DATA_BITS-1:0];
          end
        end
        OP_ROTATE: begin
          if (pos_c != '0 && pos_c < n_c) begin
            cmd.kind  = CELL_ROTATE;
            rot_start = 1'b1;
          end
        end
        OP_TRUNCATE: begin
          if (pos_c < n_c) begin
            count_d = pos_c[CNT_W-1:0];
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Control state and the result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      count_q  <= '0;
      steps_q  <= '0;
      rdata_q  <= '0;
      status_q <= ST_OK;
      ecount_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q  <= count_d;
            rdata_q  <= rdata_d;
            status_q <= status_d;
            ecount_q <= cnt_ext[POS_BITS-1:0];
            if (rot_start && pos_c > CMP_W'(1)) begin
              // The first step happened at this edge; the rest follow one a cycle.
              state_q <= S_ROTATE;
              steps_q <= pos_c[CNT_W-1:0] - CNT_W'(1);
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        S_ROTATE: begin
          steps_q <= steps_q - CNT_W'(1);
          if (steps_q == CNT_W'(1)) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_q == S_ROTATE);
  assign done_o          = done_q;
  assign read_data_o     = rdata_q;
  assign status_o        = status_q;
  assign element_count_o = ecount_q;

`ifndef NO_ASSERTIONS
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while a rotation is still running");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("live count exceeds capacity");

  a_read_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OP_READ) |=> done_o)
    else $error("read result not strobed in the next cycle");

  a_full_at_capacity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_q == CNT_W'(DEPTH)))
    else $error("full status while the list has room");

  a_count_stable_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(count_q))
    else $error("live count changed during a rotation");
`endif

endmodule

`default_nettype wire

>>> rtl/ilie_cell.sv
// One storage cell of the list: holds a single word and takes a new one from
// the input word or a neighbor. Depends on ilie_pkg.
`default_nettype none

module ilie_cell
  import ilie_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire cell_cmd_t            cmd_i,
  input  wire logic [CNT_W-1:0]     index_i,
  input  wire logic [WORD_BITS-1:0] value_i,
  input  wire logic [WORD_BITS-1:0] lower_i,
  input  wire logic [WORD_BITS-1:0] upper_i,
  input  wire logic [WORD_BITS-1:0] front_i,
  output logic      [WORD_BITS-1:0] word_o
);

  logic [WORD_BITS-1:0] word_q;
  logic [WORD_BITS-1:0] word_d;
  logic [CNT_W:0]       idx_w;
  logic [CNT_W:0]       idx_p1;
  logic [CNT_W:0]       pos_w;
  logic [CNT_W:0]       cnt_w;

  assign idx_w  = {1'b0, index_i};
  assign idx_p1 = idx_w + (CNT_W + 1)'(1);
  assign pos_w  = {1'b0, cmd_i.pos};
  assign cnt_w  = {1'b0, cmd_i.cnt};

  always_comb begin
    word_d = word_q;
    case (cmd_i.kind)
      CELL_INSERT: begin
        // The new word lands at the position; the words above it move up by one.
        if (idx_w == pos_w) begin
          word_d = value_i;
        end else if (idx_w > pos_w && idx_w <= cnt_w) begin
          word_d = lower_i;
        end
      end
      CELL_ERASE: begin
        if (idx_w >= pos_w && idx_p1 < cnt_w) begin
          word_d = upper_i;
        end
      end
      CELL_ROTATE: begin
        // One step of a left rotation over the live words.
        if (idx_p1 < cnt_w) begin
          word_d = upper_i;
        end else if (idx_p1 == cnt_w) begin
          word_d = front_i;
        end
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

>>> dv/tb_indexed_list_insert_erase_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_insert_erase_unit: directed list edge cases, then
// random commands with idle gaps in some runs, every result word checked against a local
// list model. Depends on ilie_pkg and the unit itself.

module tb_indexed_list_insert_erase_unit;
  import ilie_pkg::*;

  // Cycles without any accepted command or result word before the run is abandoned.
  // The longest legal quiet spell is a full-length rotate plus a long random idle gap.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;

  // One result word as the unit should present it.
  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    status_e              status;
    logic [POS_BITS-1:0]  count;
  } list_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [2:0]           operation_i;
  logic [POS_BITS-1:0]  position_i;
  logic [DATA_BITS-1:0] value_i;
  logic                 done_o;
  logic [DATA_BITS-1:0] read_data_o;
  logic [1:0]           status_o;
  logic [POS_BITS-1:0]  element_count_o;

  // Local copy of the list: the stored words and how many of them are live.
  logic [DATA_BITS-1:0] list_words [DEPTH];
  int unsigned          list_len;

  // Result words predicted at acceptance and still waiting for the unit to strobe them.
  list_result_t         pending_results [$];
  list_result_t         oldest_result;

  int unsigned          mismatches;
  int unsigned          stall_cycles;
  int unsigned          words_checked;
  int unsigned          op_count [8];
  int unsigned          range_hits;
  int unsigned          full_hits;
  bit                   idle_enabled;

  indexed_list_insert_erase_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .read_data_o     (read_data_o),
    .status_o        (status_o),
    .element_count_o (element_count_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Applies one command to the local list and returns the result word it must produce.
  // Range errors are decided before fullness, as an insert past the end is always an error.
  function automatic list_result_t apply_to_list(op_e op, int unsigned pos,
                                                 logic [DATA_BITS-1:0] val);
    list_result_t         res;
    logic [DATA_BITS-1:0] snapshot [DEPTH];
    int unsigned          n;
    res.data   = '0;
    res.status = ST_OK;
    n          = list_len;
    case (op)
      OP_PUSH: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[n] = val;
          list_len      = n + 1;
        end
      end
      OP_POP: begin
        // Popping an empty list is harmless and reports success.
        if (n > 0) list_len = n - 1;
      end
      OP_INSERT: begin
        if (pos > n) begin
          res.status = ST_RANGE;
        end else if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = n; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len        = n + 1;
        end
      end
      OP_ERASE: begin
        if (pos >= n) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < n; i++) list_words[i] = list_words[i+1];
          list_len = n - 1;
        end
      end
      OP_READ: begin
        if (pos >= n) res.status = ST_RANGE;
        else          res.data   = list_words[pos];
      end
      OP_ROTATE: begin
        // Position pos becomes the new front; rotating by zero or past the end is a no-op.
        if (pos != 0 && pos < n) begin
          snapshot = list_words;
          for (int i = 0; i < n; i++) list_words[i] = snapshot[(pos + i) % n];
        end
      end
      OP_TRUNCATE: begin
        if (pos < n) list_len = pos;
      end
      default: begin
      end
    endcase
    res.count = list_len[POS_BITS-1:0];
    return res;
  endfunction

  // Presents one command word at the falling edge and holds it until the unit takes it.
  // Start stays high afterwards so back-to-back words need no gap.
  task automatic send_word(op_e op, int unsigned pos, logic [DATA_BITS-1:0] val);
    list_result_t res;
    while (idle_enabled && $urandom_range(99) < 38) begin
      @(negedge clk_i);
      start       = 1'b0;
      operation_i = 3'($urandom);
      position_i  = POS_BITS'($urandom);
      value_i     = $urandom;
    end
    @(negedge clk_i);
    start       = 1'b1;
    operation_i = op;
    position_i  = POS_BITS'(pos);
    value_i     = val;
    do @(posedge clk_i); while (busy !== 1'b0);
    res = apply_to_list(op, pos, val);
    pending_results.push_back(res);
    op_count[op]++;
    if (res.status == ST_RANGE) range_hits++;
    if (res.status == ST_FULL)  full_hits++;
  endtask

  // Empty list: popping does nothing, reads and erases fail, inserting past the end fails.
  task automatic test_empty_list();
    send_word(OP_POP,    0, '0);
    send_word(OP_READ,   0, '0);
    send_word(OP_ERASE, 16, '1);
    send_word(OP_INSERT, 1, 32'hDEAD_BEEF);
  endtask

  // Fills the list to capacity with pushes and inserts, then pushes and inserts against the
  // full list, rotates by the largest amount and reads both ends and one past the end.
  task automatic test_full_list();
    logic [DATA_BITS-1:0] val;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       val = '0;
        1:       val = '1;
        2:       val = 32'h5555_5555;
        default: val = 32'hAAAA_AAAA;
      endcase
      if (i >= 4) val = $urandom;
      if (i % 2 == 0)  send_word(OP_PUSH, 0, val);
      else if (i == 1) send_word(OP_INSERT, 0, val);
      else if (i == 3) send_word(OP_INSERT, list_len, val);   // insert at the end acts as push
      else             send_word(OP_INSERT, list_len / 2, val);
    end
    send_word(OP_PUSH,   0, 32'h1234_5678);
    send_word(OP_INSERT, 8, 32'h8765_4321);
    send_word(OP_ROTATE, DEPTH - 1, '0);
    send_word(OP_READ,   0, '0);
    send_word(OP_READ,   DEPTH - 1, '0);
    send_word(OP_READ,   DEPTH, '0);
  endtask

  // Erases at tail and head, rotates that must leave the list alone, truncates at both extremes.
  task automatic test_edits_at_edges();
    send_word(OP_ERASE,    DEPTH - 1, '0);
    send_word(OP_ROTATE,   0, '0);
    send_word(OP_ROTATE,   list_len, '0);
    send_word(OP_TRUNCATE, DEPTH, '0);
    send_word(OP_ERASE,    0, '0);
    send_word(OP_TRUNCATE, 0, '0);
  endtask

  // Random commands. The mix drifts between filling and draining so that the list spends
  // time both empty and full; most positions are legal for the current length.
  task automatic test_random_traffic(int unsigned items, bit with_idle);
    op_e                  op;
    int unsigned          pos;
    int unsigned          grow_pct;
    logic [DATA_BITS-1:0] val;
    bit                   filling;
    filling      = 1'b1;
    idle_enabled = with_idle;
    repeat (items) begin
      if ($urandom_range(39) == 0) filling = !filling;
      if (list_len == 0) filling = 1'b1;
      grow_pct = filling ? 60 : 25;
      if ($urandom_range(99) < grow_pct) begin
        op = $urandom_range(1) ? OP_PUSH : OP_INSERT;
      end else begin
        case ($urandom_range(9))
          0, 1:    op = OP_POP;
          2, 3:    op = OP_ERASE;
          4, 5, 6: op = OP_READ;
          7, 8:    op = OP_ROTATE;
          default: op = OP_TRUNCATE;
        endcase
      end
      case ($urandom_range(7))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      if ($urandom_range(99) < 15) begin
        pos = $urandom_range(DEPTH, 0);
      end else begin
        case (op)
          OP_INSERT, OP_TRUNCATE: pos = $urandom_range(list_len, 0);
          OP_ERASE, OP_READ:      pos = (list_len > 0) ? $urandom_range(list_len - 1, 0) : 0;
          OP_ROTATE:              pos = (list_len > 1) ? $urandom_range(list_len - 1, 1) : 0;
          default:                pos = $urandom_range(DEPTH, 0);
        endcase
      end
      send_word(op, pos, val);
    end
    idle_enabled = 1'b0;
  endtask

  // Result checker: each strobed word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word data=%h status=%0d count=%0d",
                   $realtime, read_data_o, status_o, element_count_o);
      end else begin
        oldest_result = pending_results.pop_front();
        words_checked++;
        if (read_data_o !== oldest_result.data || status_o !== oldest_result.status ||
            element_count_o !== oldest_result.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result mismatch: data %h/%h status %0d/%0d count %0d/%0d (exp/act)",
                     $realtime, oldest_result.data, read_data_o, oldest_result.status,
                     status_o, oldest_result.count, element_count_o);
        end
      end
    end
  end

  // Watchdog: a hung handshake shows up as a long run of cycles with nothing moving.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) stall_cycles <= 0;
    else                                             stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = '0;
    position_i   = '0;
    value_i      = '0;
    list_len     = 0;
    mismatches   = 0;
    stall_cycles = 0;
    idle_enabled = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_full_list();
    test_edits_at_edges();
    test_random_traffic(250, 1'b1);
    test_random_traffic(200, 1'b0);   // long stretch with back-to-back words
    test_random_traffic(300, 1'b1);

    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);

    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d push, %0d pop, %0d insert, %0d erase, %0d read, %0d rotate, %0d truncate.",
             op_count[OP_PUSH], op_count[OP_POP], op_count[OP_INSERT], op_count[OP_ERASE],
             op_count[OP_READ], op_count[OP_ROTATE], op_count[OP_TRUNCATE]);
    $display("Checked %0d result words, %0d out-of-range and %0d list-full; %0d mismatches.",
             words_checked, range_hits, full_hits, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ilie_pkg.sv
rtl/ilie_cell.sv
rtl/indexed_list_insert_erase_unit.sv
dv/tb_indexed_list_insert_erase_unit.sv
